[hdl/plir_pkg.sv]
`default_nettype none

package plir_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int POS_W    = 7;
    localparam int WORD_W   = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] new_word;
    } cell_cmd_t;

endpackage

`default_nettype wire

[hdl/plir_cell.sv]
`default_nettype none

module plir_cell (
    input  logic                           aclk,
    input  plir_pkg::cell_cmd_t            cmd,
    input  logic [plir_pkg::IDX_W-1:0]     cell_idx,
    input  logic [plir_pkg::WORD_W-1:0]    left_word,
    input  logic [plir_pkg::WORD_W-1:0]    right_word,
    output logic [plir_pkg::WORD_W-1:0]    word
);
    import plir_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [POS_W-1:0]  idx_ext;

    assign idx_ext = POS_W'(cell_idx);

    always_comb begin
        word_next = word_reg;
        if (cmd.ins) begin
            if (idx_ext == cmd.position) begin
                word_next = cmd.new_word;
            end else if (idx_ext > cmd.position) begin
                word_next = left_word;
            end
        end else if (cmd.rem && (idx_ext >= cmd.position)) begin
            word_next = right_word;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

`default_nettype wire

[hdl/positional_list_insert_remove.sv]
`default_nettype none
// an accepted request's result is captured in the output register at the clock edge that accepts it
// throughput: one request per cycle while m_tready is high, each cell of the row shifts in parallel
// the output register lets a new request in while the previous result is being taken
// reset: synchronous active-low aresetn empties the list and the output register
// entry storage is not cleared; only entries below the count are ever read

module positional_list_insert_remove (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // position[6:0], new_word[38:7], zero pad
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // read_word[31:0], entry_count[38:32], zero pad
    output logic [1:0]  m_tuser    // status[1:0]
);
    import plir_pkg::*;

    logic [WORD_W-1:0] words [CAPACITY];
    cell_cmd_t         cmd;

    logic              accept;
    kind_t             kind;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] in_word;
    logic [WORD_W-1:0] sel_word;

    logic [POS_W-1:0]  count_reg;
    logic [POS_W-1:0]  count_next;
    logic              m_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic [POS_W-1:0]  cnt_out_reg;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign kind     = kind_t'(s_tuser);
    assign pos      = s_tdata[POS_W-1:0];
    assign in_word  = s_tdata[POS_W+WORD_W-1:POS_W];
    assign sel_word = words[pos[IDX_W-1:0]];

    always_comb begin
        status_next  = ST_DONE;
        data_next    = '0;
        count_next   = count_reg;
        cmd.ins      = 1'b0;
        cmd.rem      = 1'b0;
        cmd.position = pos;
        cmd.new_word = in_word;
        case (kind)
            KIND_INSERT: begin
                if (pos > count_reg) begin
                    status_next = ST_RANGE;
                end else if (count_reg == POS_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.ins    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (pos >= count_reg) begin
                    status_next = ST_RANGE;
                end else begin
                    data_next  = sel_word;
                    cmd.rem    = accept;
                    count_next = count_reg - 1'b1;
                end
            end
            KIND_READ: begin
                if (pos >= count_reg) begin
                    status_next = ST_RANGE;
                end else begin
                    data_next = sel_word;
                end
            end
            default: begin
                status_next = ST_DONE;
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_W-1:0] left_w;
        logic [WORD_W-1:0] right_w;
        if (g == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = words[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = words[g+1];
        end
        plir_cell u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .cell_idx   (IDX_W'(g)),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            data_reg    <= data_next;
            cnt_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, cnt_out_reg, data_reg};

endmodule

`default_nettype wire

[tb/positional_list_insert_remove_test.sv]
`default_nettype none

module positional_list_insert_remove_test;
    import plir_pkg::*;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] word;
        logic [POS_W-1:0]  count;
    } list_answer_t;

    class list_scoreboard;
        logic [WORD_W-1:0] cells [CAPACITY];
        int unsigned       fill;
        list_answer_t      answers [$];
        int                errors;
        int                n_insert, n_remove, n_read, n_unused;
        int                n_full, n_range, peak;

        function new();
            fill = 0;
            errors = 0;
            n_insert = 0;
            n_remove = 0;
            n_read = 0;
            n_unused = 0;
            n_full = 0;
            n_range = 0;
            peak = 0;
        endfunction

        function void note_request(kind_t k, logic [POS_W-1:0] p, logic [WORD_W-1:0] w);
            list_answer_t a;
            int unsigned  i;
            a.status = ST_DONE;
            a.word = '0;
            case (k)
                KIND_INSERT: begin
                    n_insert++;
                    if (p > fill) begin
                        a.status = ST_RANGE;
                    end else if (fill >= CAPACITY) begin
                        a.status = ST_FULL;
                    end else begin
                        for (i = fill; i > p; i--)
                            cells[i] = cells[i-1];
                        cells[p] = w;
                        fill++;
                    end
                end
                KIND_REMOVE: begin
                    n_remove++;
                    if (p >= fill) begin
                        a.status = ST_RANGE;
                    end else begin
                        a.word = cells[p];
                        for (i = p; i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                    end
                end
                KIND_READ: begin
                    n_read++;
                    if (p >= fill)
                        a.status = ST_RANGE;
                    else
                        a.word = cells[p];
                end
                default: n_unused++;
            endcase
            if (a.status == ST_FULL)
                n_full++;
            if (a.status == ST_RANGE)
                n_range++;
            if (fill > peak)
                peak = fill;
            a.count = fill[POS_W-1:0];
            answers.push_back(a);
        endfunction

        function void check_result(logic [1:0] st, logic [39:0] d);
            list_answer_t a;
            if (answers.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending: status %0d word %h count %0d",
                         $time, st, d[31:0], d[38:32]);
                return;
            end
            a = answers.pop_front();
            if (st !== a.status) begin
                errors++;
                $display("%0t: status expected %0d actual %0d", $time, a.status, st);
            end
            if (d[31:0] !== a.word) begin
                errors++;
                $display("%0t: read_word expected %h actual %h", $time, a.word, d[31:0]);
            end
            if (d[38:32] !== a.count) begin
                errors++;
                $display("%0t: entry_count expected %0d actual %0d", $time, a.count,
                         d[38:32]);
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    list_scoreboard sb;
    bit             src_idle = 1'b1;
    bit             sink_idle = 1'b1;
    int             sent = 0;

    positional_list_insert_remove i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic send_request(input kind_t k, input logic [POS_W-1:0] p,
                                input logic [WORD_W-1:0] w);
        int gap;
        gap = src_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {1'b0, w, p};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(k, p, w);
        sent++;
    endtask

    // mode 0 grows the list, 1 shrinks it, 2 mixes
    task automatic random_request(input int mode);
        kind_t             k;
        int                roll;
        int                pos;
        logic [WORD_W-1:0] w;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       k = (roll < 85) ? KIND_INSERT : (roll < 90) ? KIND_REMOVE : KIND_READ;
            1:       k = (roll < 80) ? KIND_REMOVE : (roll < 85) ? KIND_INSERT : KIND_READ;
            default: k = (roll < 40) ? KIND_INSERT : (roll < 70) ? KIND_REMOVE : KIND_READ;
        endcase
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0:       w = 32'h8000_0000;
                1:       w = 32'h7fff_ffff;
                2:       w = 32'h0000_0000;
                default: w = 32'hffff_ffff;
            endcase
        end else begin
            w = $urandom;
        end
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            // noise: any kind, any position
            k = kind_t'($urandom_range(0, 3));
            pos = $urandom_range(0, 127);
        end else if (roll < 13) begin
            pos = sb.fill + ((k == KIND_INSERT) ? 1 : 0) + $urandom_range(0, 10);
        end else if (k == KIND_INSERT) begin
            pos = $urandom_range(0, sb.fill);
        end else begin
            pos = (sb.fill == 0) ? 0 : $urandom_range(0, sb.fill - 1);
        end
        if (pos > 127)
            pos = 127;
        send_request(k, pos[POS_W-1:0], w);
    endtask

    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = sink_idle ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tuser, m_tdata);
        end
    end

    initial begin
        int mode;
        int len;
        int n;
        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty list edges
        send_request(KIND_READ,   7'd0,   32'h1234_5678);
        send_request(KIND_REMOVE, 7'd0,   32'h0);
        send_request(KIND_INSERT, 7'd1,   32'h1111_1111);
        // insert at front, end and middle
        send_request(KIND_INSERT, 7'd0,   32'h8000_0000);
        send_request(KIND_INSERT, 7'd1,   32'h7fff_ffff);
        send_request(KIND_INSERT, 7'd0,   32'h0000_0000);
        send_request(KIND_INSERT, 7'd1,   32'hffff_ffff);
        for (n = 0; n < 4; n++)
            send_request(KIND_READ, n[POS_W-1:0], 32'h0);
        send_request(KIND_READ,   7'd4,   32'h0);
        send_request(KIND_READ,   7'd127, 32'h0);
        send_request(KIND_INSERT, 7'd127, 32'hdead_beef);
        send_request(KIND_NONE,   7'd0,   32'hffff_ffff);
        send_request(KIND_NONE,   7'd127, 32'h0);
        // remove from middle, end and front
        send_request(KIND_REMOVE, 7'd1,   32'h0);
        send_request(KIND_REMOVE, 7'd2,   32'h0);
        send_request(KIND_REMOVE, 7'd0,   32'h0);
        send_request(KIND_REMOVE, 7'd1,   32'h0);
        send_request(KIND_READ,   7'd0,   32'h0);
        send_request(KIND_REMOVE, 7'd0,   32'h0);
        send_request(KIND_INSERT, 7'd0,   32'h5a5a_a5a5);

        // grow, mix, shrink, mix: grow phases run long enough to hit a full list
        mode = 0;
        while (sent < 1820) begin
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            len = (mode == 2) ? $urandom_range(30, 80) : $urandom_range(80, 120);
            for (n = 0; n < len; n++)
                random_request(mode);
            case (mode)
                0:       mode = 2;
                2:       mode = (sb.fill > 32) ? 1 : 0;
                default: mode = 2;
            endcase
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d requests: %0d inserts, %0d removes, %0d reads, %0d unused kinds",
                 sent, sb.n_insert, sb.n_remove, sb.n_read, sb.n_unused);
        $display("%0d full-list answers, %0d out-of-range answers, peak of %0d entries",
                 sb.n_full, sb.n_range, sb.peak);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

`default_nettype wire
